FILE: sv/pitch_ratio_period_scaler_core_defines.svh
// Assertion macros for the pitch ratio period scaler RTL.
`ifndef PITCH_RATIO_PERIOD_SCALER_CORE_DEFINES_SVH
`define PITCH_RATIO_PERIOD_SCALER_CORE_DEFINES_SVH

// Checks that a property holds at every clock edge out of reset.
`define PRPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds out of reset.
`define PRPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/prps_pkg.sv
// Types, constants and helper functions of the pitch ratio period scaler.
`default_nettype none

package prps_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int RATIO_FRAC_BITS = 12;
  localparam int BLEND_BITS = 8;
  localparam logic [31:0] UNITY_RATIO = 32'(1) << RATIO_FRAC_BITS;
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = 32 / DIV_STEP;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_COMPUTE = 2'd0;
  localparam logic [1:0] MODE_LOAD_UP = 2'd1;
  localparam logic [1:0] MODE_LOAD_DOWN = 2'd2;

  localparam logic [1:0] REG_RATE_DIVISOR = 2'd0;

  typedef enum logic [1:0] {
    KIND_LOAD_UP,
    KIND_LOAD_DOWN,
    KIND_COMPUTE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  wr_idx;
    logic [15:0]       word;
    logic [IDX_W-1:0]  lo_idx;
    logic [IDX_W-1:0]  hi_idx;
    logic              down;
    logic              unity;
    logic [7:0]        frac;
    logic [15:0]       base;
  } item_t;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [8:0] v);
    logic [IDX_W-1:0] r;
    if (v > 9'(TABLE_DEPTH - 1)) begin
      r = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      r = IDX_W'(v);
    end
    return r;
  endfunction

  // One radix-2 restoring step per dividend bit; returns {remainder, quotient bits}.
  function automatic logic [15+DIV_STEP:0] div_step(input logic [15:0] rem_in,
                                                    input logic [DIV_STEP-1:0] bits,
                                                    input logic [15:0] d);
    logic [16:0]         r;
    logic [15:0]         rem;
    logic [DIV_STEP-1:0] q;
    rem = rem_in;
    q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      r = {rem, bits[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
      rem = r[15:0];
    end
    return {rem, q};
  endfunction

endpackage

`default_nettype wire

FILE: sv/prps_front.sv
// Front end: accepts input items, drops void ones and works out table indexes.
`default_nettype none

module prps_front import prps_pkg::*; (
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  table_index_i,
  input  wire logic [15:0] table_word_i,
  input  wire logic [6:0]  anchor_note_i,
  input  wire logic [6:0]  target_note_i,
  input  wire logic [7:0]  fraction_i,
  input  wire logic [15:0] base_period_i,
  input  wire logic        full_i,
  output logic             push_o,
  output item_t            item_o
);

  logic       ge;
  logic [6:0] diff;
  logic       keep;
  logic       in_range;

  assign in_stall_o = full_i;
  assign ge = target_note_i >= anchor_note_i;
  assign diff = ge ? (target_note_i - anchor_note_i) : (anchor_note_i - target_note_i);
  assign in_range = 9'(table_index_i) < 9'(TABLE_DEPTH);

  always_comb begin
    item_o.wr_idx = IDX_W'(table_index_i);
    item_o.word   = table_word_i;
    item_o.lo_idx = clamp_idx(9'(diff));
    item_o.hi_idx = clamp_idx(9'(diff) + 9'd1);
    item_o.down   = !ge;
    item_o.unity  = (fraction_i == 8'd0) && (target_note_i == anchor_note_i);
    item_o.frac   = fraction_i;
    item_o.base   = base_period_i;
    case (mode_i)
      MODE_COMPUTE: begin
        item_o.kind = KIND_COMPUTE;
        keep = 1'b1;
      end
      MODE_LOAD_UP: begin
        item_o.kind = KIND_LOAD_UP;
        keep = in_range;
      end
      MODE_LOAD_DOWN: begin
        item_o.kind = KIND_LOAD_DOWN;
        keep = in_range;
      end
      default: begin
        item_o.kind = KIND_COMPUTE;
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && !full_i && keep;

endmodule

`default_nettype wire

FILE: sv/prps_queue.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none
`include "pitch_ratio_period_scaler_core_defines.svh"

module prps_queue import prps_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_pop;

  assign full_o = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o = mem_q[rd_q];
  assign do_pop = pop_i && valid_o;
  assign count_d = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(do_pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= QPTR_W'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= QPTR_W'(rd_q + 1'b1);
      end
      count_q <= count_d;
    end
  end

  `PRPS_ASSERT(a_count_track, ##1 (count_q == $past(count_d)), "queue count lost track")
  `PRPS_NEVER(a_count_bound, count_q > (QPTR_W+1)'(QUEUE_DEPTH), "queue count above depth")
  `PRPS_NEVER(a_push_full, push_i && full_o, "push into a full queue")

endmodule

`default_nettype wire

FILE: sv/prps_div.sv
// Pipelined restoring divider, four quotient bits per stage.
`default_nettype none

module prps_div import prps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             valid_o,
  output logic [15:0]      quot_o
);

  logic        v_q   [DIV_STAGES];
  logic [15:0] rem_q [DIV_STAGES];
  logic [31:0] dvd_q [DIV_STAGES];
  logic [15:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              v_in;
    logic [15:0]       rem_in;
    logic [31:0]       dvd_in;
    logic [15:0]       quo_in;
    logic [15+DIV_STEP:0] step;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign step = div_step(rem_in, dvd_in[31 -: DIV_STEP], divisor_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= step[15+DIV_STEP:DIV_STEP];
        dvd_q[k] <= dvd_in << DIV_STEP;
        quo_q[k] <= {quo_in[15-DIV_STEP:0], step[DIV_STEP-1:0]};
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/prps_back.sv
// Back end: ratio tables, blend, period multiply, divide and output register.
`default_nettype none

module prps_back import prps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire item_t       q_item_i,
  output logic             pop_o,
  input  wire logic [15:0] rate_divisor_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      period_o
);

  logic [15:0] up_mem [TABLE_DEPTH];
  logic [15:0] dn_mem [TABLE_DEPTH];

  logic        en;
  logic        s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic [15:0] up_lo_q, up_hi_q, dn_lo_q, dn_hi_q;
  logic        s1_down_q, s1_unity_q;
  logic [7:0]  s1_frac_q;
  logic [15:0] s1_base_q, s2_base_q;
  logic [31:0] ratio_q, prod_q;
  logic [15:0] period_q;
  logic [15:0] lo, hi;
  logic [31:0] delta, blend, ratio_d;
  logic        div_v;
  logic [15:0] div_q;

  assign en = !(out_v_q && out_stall_i);
  assign pop_o = q_valid_i && en;

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.kind == KIND_LOAD_UP) begin
      up_mem[q_item_i.wr_idx] <= q_item_i.word;
    end
    if (pop_o && q_item_i.kind == KIND_LOAD_DOWN) begin
      dn_mem[q_item_i.wr_idx] <= q_item_i.word;
    end
    if (en) begin
      up_lo_q <= up_mem[q_item_i.lo_idx];
      up_hi_q <= up_mem[q_item_i.hi_idx];
      dn_lo_q <= dn_mem[q_item_i.lo_idx];
      dn_hi_q <= dn_mem[q_item_i.hi_idx];
    end
  end

  assign lo = s1_down_q ? dn_lo_q : up_lo_q;
  assign hi = s1_down_q ? dn_hi_q : up_hi_q;
  assign delta = s1_down_q ? (32'(lo) - 32'(hi)) : (32'(hi) - 32'(lo));
  assign blend = delta * 32'(s1_frac_q);
  assign ratio_d = s1_unity_q ? UNITY_RATIO : (32'(lo) + (blend >> BLEND_BITS));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_down_q <= q_item_i.down;
      s1_unity_q <= q_item_i.unity;
      s1_frac_q <= q_item_i.frac;
      s1_base_q <= q_item_i.base;
      ratio_q <= ratio_d;
      s2_base_q <= s1_base_q;
      prod_q <= 32'(s2_base_q) * ratio_q;
      period_q <= (rate_divisor_i == 16'd0) ? 16'hFFFF : div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= pop_o && q_item_i.kind == KIND_COMPUTE;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      out_v_q <= div_v;
    end
  end

  prps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s3_v_q),
    .dividend_i (prod_q),
    .divisor_i  (rate_divisor_i),
    .valid_o    (div_v),
    .quot_o     (div_q)
  );

  assign out_valid_o = out_v_q;
  assign period_o = period_q;

endmodule

`default_nettype wire

FILE: sv/pitch_ratio_period_scaler_core.sv
// Top level of the pitch ratio period scaler: register port, front end, queue, back end.
//
// The input channel carries compute items and table load items. A load item
// writes one Q4.12 word into the up or down ratio table and gives no result;
// a compute item gives exactly one period on the output channel.
// Items with an unused mode, and loads past the table, are dropped.
// A transfer happens on a channel when valid is high and stall is low.
// One item is taken per cycle while the input stall is low; a compute result passes
// through the queue, the table read, the blend and period multiplies, the eight-stage
// divider that retires four quotient bits per stage and the output register.
// When the receiver stalls, the whole back end holds; the four-entry queue
// keeps taking input until it fills, then the input stall rises.
// Reset clears the pipeline valid flags and queue pointers and sets rate_divisor to
// one. The ratio tables are not cleared and must be loaded before use. The user must
// write rate_divisor over the APB port only while the block is idle; it is not enforced.
`default_nettype none

module pitch_ratio_period_scaler_core import prps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  table_index_i,
  input  wire logic [15:0] table_word_i,
  input  wire logic [6:0]  anchor_note_i,
  input  wire logic [6:0]  target_note_i,
  input  wire logic [7:0]  fraction_i,
  input  wire logic [15:0] base_period_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      period_o
);

  logic [15:0] rate_div_q;
  logic        push, full, q_valid, pop;
  item_t       f_item, q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_RATE_DIVISOR) ? {16'd0, rate_div_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_div_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr == REG_RATE_DIVISOR) begin
      rate_div_q <= pwdata[15:0];
    end
  end

  prps_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .table_index_i (table_index_i),
    .table_word_i  (table_word_i),
    .anchor_note_i (anchor_note_i),
    .target_note_i (target_note_i),
    .fraction_i    (fraction_i),
    .base_period_i (base_period_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (f_item)
  );

  prps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  prps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .rate_divisor_i (rate_div_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .period_o       (period_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the pitch ratio period scaler core.
`default_nettype none

module tb;
  import prps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class period_scoreboard;
    logic [15:0] up_tab[TABLE_DEPTH];
    logic [15:0] down_tab[TABLE_DEPTH];
    logic [15:0] divisor;
    logic [15:0] pending_periods[$];
    int errors;
    int checked;

    function new();
      divisor = 16'd1;
      errors = 0;
      checked = 0;
    endfunction

    function automatic logic [31:0] entry(bit down, int unsigned idx);
      if (idx > TABLE_DEPTH - 1) begin
        idx = TABLE_DEPTH - 1;
      end
      return down ? 32'(down_tab[idx]) : 32'(up_tab[idx]);
    endfunction

    function void note_input(logic [1:0] mode, logic [6:0] tidx, logic [15:0] word,
                             logic [6:0] a, logic [6:0] b, logic [7:0] c, logic [15:0] s);
      logic [31:0] lo, hi, delta, ratio, prod, quot;
      if (mode == MODE_LOAD_UP) begin
        up_tab[tidx] = word;
      end else if (mode == MODE_LOAD_DOWN) begin
        down_tab[tidx] = word;
      end else if (mode == MODE_COMPUTE) begin
        if (c == 8'd0) begin
          if (b == a) begin
            ratio = UNITY_RATIO;
          end else if (a < b) begin
            ratio = entry(1'b0, 32'(b) - 32'(a));
          end else begin
            ratio = entry(1'b1, 32'(a) - 32'(b));
          end
        end else begin
          if (b >= a) begin
            lo = entry(1'b0, 32'(b) - 32'(a));
            hi = entry(1'b0, 32'(b) - 32'(a) + 32'd1);
            delta = hi - lo;
          end else begin
            lo = entry(1'b1, 32'(a) - 32'(b));
            hi = entry(1'b1, 32'(a) - 32'(b) + 32'd1);
            delta = lo - hi;
          end
          ratio = lo + ((delta * 32'(c)) >> BLEND_BITS);
        end
        prod = ratio * 32'(s);
        quot = (divisor == 16'd0) ? 32'hFFFF_FFFF : prod / 32'(divisor);
        pending_periods.push_back(quot[15:0]);
      end
    endfunction

    function void check_period(logic [15:0] got);
      logic [15:0] exp_p;
      if (pending_periods.size() == 0) begin
        $display("%0t: unexpected period, expected none actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_p = pending_periods.pop_front();
      checked++;
      if (got !== exp_p) begin
        $display("%0t: period mismatch, expected %h actual %h", $realtime, exp_p, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 0, in_stall_o;
  logic [1:0] mode_i = '0;
  logic [6:0] table_index_i = '0, anchor_note_i = '0, target_note_i = '0;
  logic [15:0] table_word_i = '0, base_period_i = '0;
  logic [7:0] fraction_i = '0;
  logic out_valid_o, out_stall_i = 0;
  logic [15:0] period_o;

  period_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit hold_off = 0;
  bit no_stall = 0;
  bit done = 0;

  pitch_ratio_period_scaler_core u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_period(period_o);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (no_stall) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send(logic [1:0] m, logic [6:0] ti, logic [15:0] w,
                      logic [6:0] a, logic [6:0] b, logic [7:0] c, logic [15:0] s);
    in_valid_i <= 1'b1;
    mode_i <= m;
    table_index_i <= ti;
    table_word_i <= w;
    anchor_note_i <= a;
    target_note_i <= b;
    fraction_i <= c;
    base_period_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(m, ti, w, a, b, c, s);
    sent++;
  endtask

  task automatic pause_gap();
    int g;
    g = $urandom_range(0, 3);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_divisor(logic [15:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending_periods.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_RATE_DIVISOR; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.divisor = v;
    @(posedge clk_i);
  endtask

  task automatic random_compute();
    logic [6:0] a, b;
    a = 7'($urandom_range(0, 127));
    b = ($urandom_range(0, 7) == 0) ? a : 7'($urandom_range(0, 127));
    send(MODE_COMPUTE, 7'($urandom), 16'($urandom), a, b,
         ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: send(MODE_LOAD_UP, 7'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                8'($urandom), 16'($urandom));
        1: send(MODE_LOAD_DOWN, 7'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                8'($urandom), 16'($urandom));
        2: send(2'd3, 7'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                8'($urandom), 16'($urandom));
        default: random_compute();
      endcase
      if ($urandom_range(0, 7) == 0) pause_gap();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    no_stall = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send(MODE_LOAD_UP, 7'(i), (i == 5) ? 16'hFFFF : 16'($urandom), '0, '0, '0, '0);
      send(MODE_LOAD_DOWN, 7'(i), (i == 6) ? 16'h0000 : 16'($urandom), '0, '0, '0, '0);
    end
    send(MODE_COMPUTE, '0, '0, 7'd40, 7'd40, 8'd0, 16'hFFFF);
    send(MODE_COMPUTE, '0, '0, 7'd0, 7'd127, 8'd0, 16'hFFFF);
    send(MODE_COMPUTE, '0, '0, 7'd127, 7'd0, 8'd0, 16'd1);
    send(MODE_COMPUTE, '0, '0, 7'd0, 7'd127, 8'd255, 16'hFFFF);
    send(MODE_COMPUTE, '0, '0, 7'd127, 7'd0, 8'd1, 16'h1234);
    send(MODE_COMPUTE, '0, '0, 7'd10, 7'd10, 8'd128, 16'h8000);
    send(MODE_COMPUTE, '0, '0, 7'd0, 7'd4, 8'd200, 16'hABCD);
    send(MODE_COMPUTE, '0, '0, 7'd12, 7'd6, 8'd77, 16'd0);
    send(2'd3, 7'd3, 16'hFFFF, 7'd1, 7'd2, 8'd3, 16'd4);
    no_stall = 1'b0;
    write_divisor(16'd0);
    send(MODE_COMPUTE, '0, '0, 7'd3, 7'd9, 8'd0, 16'h0100);
    random_phase(40);
    write_divisor(16'hFFFF);
    random_phase(150);
    write_divisor(16'd1);
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(60);
    join
    random_phase(300);
    write_divisor(16'd3);
    random_phase(300);
    write_divisor(16'($urandom_range(2, 65534)));
    random_phase(100);
    in_valid_i <= 1'b0;
    while (sb.pending_periods.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("tb: %0d items sent, %0d periods checked, divisor extremes and long stall",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_periods.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
